@@ hw/rtl/isotp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_pkg
// Shared types, field widths and codes of the ISO-TP receive reassembler.
// ----------------------------------------------------------------------------
package isotp_pkg;

    localparam int OP_W        = 2;
    localparam int FID_W       = 29;
    localparam int FLEN_W      = 4;
    localparam int FB_W        = 64;
    localparam int RIDX_W      = 12;
    localparam int EV_W        = 3;
    localparam int PHASE_W     = 3;
    localparam int TOTAL_W     = 12;
    localparam int RCVD_W      = 13;
    localparam int SEQ_W       = 4;
    localparam int ELAPSED_W   = 16;
    localparam int BYTE_W      = 8;
    localparam int LANES       = 8;
    localparam int LANE_W      = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 104;

    localparam logic [ELAPSED_W-1:0] TIMEOUT_RST  = 16'd1000;
    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX  = 16'hFFFF;
    localparam logic [FID_W-1:0]     FC_ID_OFFSET = 29'd8;
    localparam logic [3:0]           PCI_FIRST    = 4'h1;
    localparam logic [3:0]           PCI_CONSEC   = 4'h2;
    localparam logic [FLEN_W-1:0]    LEN_MAX      = 4'd8;
    localparam logic [FLEN_W-1:0]    FF_MIN_LEN   = 4'd3;
    localparam logic [FLEN_W-1:0]    CF_MIN_LEN   = 4'd2;
    localparam logic [FLEN_W-1:0]    FF_PCI_BYTES = 4'd2;
    localparam logic [FLEN_W-1:0]    CF_PCI_BYTES = 4'd1;
    localparam logic [TOTAL_W-1:0]   SHORT_TOTAL  = 12'd7;
    localparam logic [SEQ_W-1:0]     SEQ_FIRST    = 4'd1;
    localparam logic [SEQ_W-1:0]     SEQ_STEP     = 4'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

    localparam logic [PHASE_W-1:0] PHASE_IDLE    = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_WAIT_CF = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_DONE    = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_TIMEOUT = 3'd4;

    typedef enum logic [OP_W-1:0] {
        OP_FRAME = 2'd0,
        OP_TICK  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    typedef enum logic [EV_W-1:0] {
        EV_NONE     = 3'd0,
        EV_FIRST    = 3'd1,
        EV_NEXT     = 3'd2,
        EV_COMPLETE = 3'd3,
        EV_SEQ_RST  = 3'd4,
        EV_OVF_RST  = 3'd5,
        EV_TIMEOUT  = 3'd6,
        EV_IGNORED  = 3'd7
    } t_event;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_WAIT_CF = 4'b0010,
        PH_DONE    = 4'b0100,
        PH_TIMEOUT = 4'b1000
    } t_phase;

    typedef struct packed {
        t_op                 op;
        logic [FID_W-1:0]    frame_id;
        logic [FLEN_W-1:0]   frame_len;
        logic [FB_W-1:0]     frame_bytes;
        logic [RIDX_W-1:0]   read_index;
    } t_item;

    typedef struct packed {
        logic                 enable;
        logic [ELAPSED_W-1:0] timeout_ms;
    } t_cfg;

    typedef struct packed {
        t_event              ev;
        logic [PHASE_W-1:0]  phase;
        logic                fc_send;
        logic [FID_W-1:0]    fc_id;
        logic [TOTAL_W-1:0]  msg_total;
        logic [RCVD_W-1:0]   msg_received;
        logic [FID_W-1:0]    msg_id;
    } t_result;

    typedef struct packed {
        logic                en;
        logic                wr;
        logic [RCVD_W-1:0]   start;
        logic [LANE_W-1:0]   src_off;
        logic [LANE_W-1:0]   count;
        logic                rd_ok;
        logic [RIDX_W-1:0]   rd_index;
    } t_store_cmd;

    function automatic logic [PHASE_W-1:0] phase_code(t_phase p);
        logic [PHASE_W-1:0] code;
        case (p)
            PH_WAIT_CF: code = PHASE_WAIT_CF;
            PH_DONE:    code = PHASE_DONE;
            PH_TIMEOUT: code = PHASE_TIMEOUT;
            default:    code = PHASE_IDLE;
        endcase
        return code;
    endfunction

endpackage

@@ hw/rtl/isotp_receive_reassembler_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_receive_reassembler_core
// ISO-TP receive reassembly of classic CAN frames with payload buffer.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  s_axis   | in  | tuser: op; tdata: frame_id, frame_len, frame_bytes, read_index
//  m_axis   | out | tdata: event_res, phase, fc_send, fc_id, msg_total,
//           |     |        msg_received, msg_id, read_byte
//  cfg      | in  | i_cfg_addr 0 enable, 1 timeout_ms
//
//  One transfer per cycle sustained while m_axis is not stalled; an accepted
//  item passes the input register, then session logic into the result register.
//  Throughput is set by the combinational session update and one write and
//  one read per payload bank per cycle.
//  Reset: session registers cleared, config set to enable on, timeout_ms 1000;
//  payload banks are not cleared, so no start-up pass.
//  m_axis stall holds the result and one more item in the input register.
// ----------------------------------------------------------------------------
module isotp_receive_reassembler_core #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [28:0] frame_id, [32:29] frame_len, [96:33] frame_bytes, [108:97] read_index
    input  logic [isotp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [1:0] op
    input  logic [isotp_pkg::OP_W-1:0]            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [2:0] event_res, [5:3] phase, [6] fc_send, [35:7] fc_id, [47:36] msg_total,
    // [60:48] msg_received, [89:61] msg_id, [97:90] read_byte
    output logic [isotp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                  i_cfg_we,
    input  logic [isotp_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  logic [isotp_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    localparam int OUT_USED = isotp_pkg::EV_W + isotp_pkg::PHASE_W + 1
                              + 2 * isotp_pkg::FID_W + isotp_pkg::TOTAL_W
                              + isotp_pkg::RCVD_W + isotp_pkg::BYTE_W;

    isotp_pkg::t_cfg        r_cfg;
    isotp_pkg::t_item       r_a_item;
    logic                   r_a_valid;
    logic                   r_b_valid;
    isotp_pkg::t_result     r_b_result;
    isotp_pkg::t_result     result;
    isotp_pkg::t_store_cmd  cmd;
    logic [isotp_pkg::BYTE_W-1:0] read_byte;
    logic                   s_fire;
    logic                   a_fire;

    assign a_fire        = r_a_valid && (!r_b_valid || m_axis_tready);
    assign s_axis_tready = !r_a_valid || a_fire;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable     <= 1'b1;
            r_cfg.timeout_ms <= isotp_pkg::TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                isotp_pkg::CFG_ENABLE:  r_cfg.enable     <= i_cfg_wdata[0];
                isotp_pkg::CFG_TIMEOUT: r_cfg.timeout_ms <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= s_fire || (r_a_valid && !a_fire);
            r_b_valid <= a_fire || (r_b_valid && !m_axis_tready);
        end
        if (s_fire) begin
            r_a_item.op          <= isotp_pkg::t_op'(s_axis_tuser);
            r_a_item.frame_id    <= s_axis_tdata[28:0];
            r_a_item.frame_len   <= s_axis_tdata[32:29];
            r_a_item.frame_bytes <= s_axis_tdata[96:33];
            r_a_item.read_index  <= s_axis_tdata[108:97];
        end
        if (a_fire) begin
            r_b_result <= result;
        end
    end

    isotp_sess #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_sess (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (a_fire),
        .i_item   (r_a_item),
        .i_cfg    (r_cfg),
        .o_result (result),
        .o_cmd    (cmd)
    );

    isotp_store #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_store (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_frame_bytes (r_a_item.frame_bytes),
        .o_read_byte   (read_byte)
    );

    assign m_axis_tvalid = r_b_valid;
    assign m_axis_tdata  = {(isotp_pkg::OUT_TDATA_W - OUT_USED)'(0),
                            read_byte,
                            r_b_result.msg_id,
                            r_b_result.msg_received,
                            r_b_result.msg_total,
                            r_b_result.fc_id,
                            r_b_result.fc_send,
                            r_b_result.phase,
                            r_b_result.ev};

    a_fc_only_on_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_result.fc_send |-> r_b_result.ev == isotp_pkg::EV_FIRST)
        else $error("flow control requested without first frame");

    a_timeout_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_result.ev == isotp_pkg::EV_TIMEOUT
        |-> r_b_result.phase == isotp_pkg::PHASE_TIMEOUT)
        else $error("timeout event without timed-out phase");

    a_received_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> r_b_result.msg_received <= isotp_pkg::RCVD_W'(BUFFER_BYTES))
        else $error("stored count beyond buffer");

    a_done_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_result.phase == isotp_pkg::PHASE_DONE
        |-> r_b_result.msg_received >= isotp_pkg::RCVD_W'(r_b_result.msg_total))
        else $error("complete with fewer bytes than announced");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_a_valid && r_b_valid && !m_axis_tready)
        else $error("input held off without output stall");

endmodule

@@ hw/rtl/isotp_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module isotp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/isotp_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_store
// Payload buffer as eight byte banks; writes up to seven consecutive bytes
// and reads one byte per transfer.
// ----------------------------------------------------------------------------
module isotp_store #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  isotp_pkg::t_store_cmd         i_cmd,
    input  logic [isotp_pkg::FB_W-1:0]    i_frame_bytes,
    output logic [isotp_pkg::BYTE_W-1:0]  o_read_byte
);

    localparam int ROWS  = (BUFFER_BYTES + isotp_pkg::LANES - 1) / isotp_pkg::LANES;
    localparam int ROW_W = $clog2(ROWS);

    logic [isotp_pkg::BYTE_W-1:0] lane_rdata [isotp_pkg::LANES];
    logic [isotp_pkg::LANE_W-1:0] r_rd_lane;
    logic                         r_rd_ok;
    logic [ROW_W-1:0]             rd_row;

    assign rd_row = ROW_W'(i_cmd.rd_index[isotp_pkg::RIDX_W-1:isotp_pkg::LANE_W]);

    for (genvar b = 0; b < isotp_pkg::LANES; b++) begin : g_lane
        logic [isotp_pkg::LANE_W-1:0] k;
        logic [isotp_pkg::LANE_W-1:0] src;
        logic                         we;
        logic                         wrap;
        logic [ROW_W-1:0]             wrow;
        logic [isotp_pkg::BYTE_W-1:0] wdata;

        always_comb begin
            k     = isotp_pkg::LANE_W'(b) - i_cmd.start[isotp_pkg::LANE_W-1:0];
            src   = k + i_cmd.src_off;
            we    = i_cmd.en && i_cmd.wr && (k < i_cmd.count);
            wrap  = isotp_pkg::LANE_W'(b) < i_cmd.start[isotp_pkg::LANE_W-1:0];
            wrow  = ROW_W'(i_cmd.start[isotp_pkg::RCVD_W-1:isotp_pkg::LANE_W])
                    + ROW_W'(wrap);
            wdata = i_frame_bytes[src*isotp_pkg::BYTE_W +: isotp_pkg::BYTE_W];
        end

        isotp_ram #(
            .WIDTH (isotp_pkg::BYTE_W),
            .DEPTH (ROWS)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (we),
            .i_waddr (wrow),
            .i_wdata (wdata),
            .i_re    (i_cmd.en),
            .i_raddr (rd_row),
            .o_rdata (lane_rdata[b])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ok <= 1'b0;
        end else if (i_cmd.en) begin
            r_rd_ok <= i_cmd.rd_ok;
        end
        if (i_cmd.en) begin
            r_rd_lane <= i_cmd.rd_index[isotp_pkg::LANE_W-1:0];
        end
    end

    assign o_read_byte = r_rd_ok ? lane_rdata[r_rd_lane] : '0;

endmodule

@@ hw/rtl/isotp_sess.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isotp_sess
// Session state and per-transfer next-state logic: frame decode, sequence
// and overflow checks, timeout, tick, session reset and read bounds check.
// ----------------------------------------------------------------------------
module isotp_sess #(
    parameter int BUFFER_BYTES = 4096
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  isotp_pkg::t_item       i_item,
    input  isotp_pkg::t_cfg        i_cfg,
    output isotp_pkg::t_result     o_result,
    output isotp_pkg::t_store_cmd  o_cmd
);

    localparam int SUM_W = isotp_pkg::RCVD_W + 1;

    isotp_pkg::t_phase                 r_phase,   n_phase;
    logic [isotp_pkg::FID_W-1:0]       r_id,      n_id;
    logic [isotp_pkg::TOTAL_W-1:0]     r_total,   n_total;
    logic [isotp_pkg::RCVD_W-1:0]      r_stored,  n_stored;
    logic [isotp_pkg::SEQ_W-1:0]       r_seq,     n_seq;
    logic [isotp_pkg::ELAPSED_W-1:0]   r_elapsed, n_elapsed;

    logic [isotp_pkg::FLEN_W-1:0]      flen_e;
    logic [isotp_pkg::FLEN_W-1:0]      cf_n;
    logic [isotp_pkg::BYTE_W-1:0]      pci;
    logic [SUM_W-1:0]                  sum;
    isotp_pkg::t_event                 ev;
    logic                              fc;
    logic [isotp_pkg::FID_W-1:0]       fcid;

    always_comb begin
        n_phase   = r_phase;
        n_id      = r_id;
        n_total   = r_total;
        n_stored  = r_stored;
        n_seq     = r_seq;
        n_elapsed = r_elapsed;
        ev        = isotp_pkg::EV_NONE;
        fc        = 1'b0;
        fcid      = '0;
        o_cmd     = '0;
        o_cmd.en  = i_fire;
        o_cmd.rd_index = i_item.read_index;

        flen_e = (i_item.frame_len > isotp_pkg::LEN_MAX) ? isotp_pkg::LEN_MAX
                                                         : i_item.frame_len;
        cf_n   = flen_e - isotp_pkg::CF_PCI_BYTES;
        pci    = i_item.frame_bytes[isotp_pkg::BYTE_W-1:0];
        sum    = SUM_W'(r_stored) + SUM_W'(cf_n);

        unique case (i_item.op)
            isotp_pkg::OP_FRAME: begin
                if (!i_cfg.enable || flen_e == '0) begin
                    ev = isotp_pkg::EV_IGNORED;
                end else begin
                    if (pci[7:4] == isotp_pkg::PCI_FIRST) begin
                        if (flen_e < isotp_pkg::FF_MIN_LEN) begin
                            ev = isotp_pkg::EV_IGNORED;
                        end else begin
                            n_phase   = isotp_pkg::PH_WAIT_CF;
                            n_id      = i_item.frame_id;
                            n_total   = {pci[3:0], i_item.frame_bytes[15:8]};
                            n_stored  = isotp_pkg::RCVD_W'(flen_e - isotp_pkg::FF_PCI_BYTES);
                            n_seq     = isotp_pkg::SEQ_FIRST;
                            n_elapsed = '0;
                            o_cmd.wr      = 1'b1;
                            o_cmd.start   = '0;
                            o_cmd.src_off = isotp_pkg::LANE_W'(isotp_pkg::FF_PCI_BYTES);
                            o_cmd.count   = isotp_pkg::LANE_W'(flen_e - isotp_pkg::FF_PCI_BYTES);
                            ev = isotp_pkg::EV_FIRST;
                            if (n_total > isotp_pkg::SHORT_TOTAL) begin
                                fc   = 1'b1;
                                fcid = i_item.frame_id - isotp_pkg::FC_ID_OFFSET;
                            end
                        end
                    end else if (pci[7:4] == isotp_pkg::PCI_CONSEC) begin
                        if (r_phase != isotp_pkg::PH_WAIT_CF || i_item.frame_id != r_id
                            || flen_e < isotp_pkg::CF_MIN_LEN) begin
                            ev = isotp_pkg::EV_IGNORED;
                        end else if (pci[3:0] != r_seq) begin
                            n_phase = isotp_pkg::PH_IDLE;
                            n_id = '0; n_total = '0; n_stored = '0; n_seq = '0; n_elapsed = '0;
                            ev = isotp_pkg::EV_SEQ_RST;
                        end else if (sum > SUM_W'(BUFFER_BYTES)) begin
                            n_phase = isotp_pkg::PH_IDLE;
                            n_id = '0; n_total = '0; n_stored = '0; n_seq = '0; n_elapsed = '0;
                            ev = isotp_pkg::EV_OVF_RST;
                        end else begin
                            o_cmd.wr      = 1'b1;
                            o_cmd.start   = r_stored;
                            o_cmd.src_off = isotp_pkg::LANE_W'(isotp_pkg::CF_PCI_BYTES);
                            o_cmd.count   = isotp_pkg::LANE_W'(cf_n);
                            n_stored  = sum[isotp_pkg::RCVD_W-1:0];
                            n_seq     = r_seq + isotp_pkg::SEQ_STEP;
                            n_elapsed = '0;
                            if (n_stored >= isotp_pkg::RCVD_W'(r_total)) begin
                                n_phase = isotp_pkg::PH_DONE;
                                ev = isotp_pkg::EV_COMPLETE;
                            end else begin
                                ev = isotp_pkg::EV_NEXT;
                            end
                        end
                    end
                    if (n_phase == isotp_pkg::PH_WAIT_CF && n_elapsed > i_cfg.timeout_ms) begin
                        n_phase = isotp_pkg::PH_TIMEOUT;
                        ev = isotp_pkg::EV_TIMEOUT;
                    end
                end
            end
            isotp_pkg::OP_TICK: begin
                if (r_elapsed != isotp_pkg::ELAPSED_MAX) begin
                    n_elapsed = r_elapsed + isotp_pkg::ELAPSED_W'(1);
                end
            end
            isotp_pkg::OP_CLEAR: begin
                n_phase = isotp_pkg::PH_IDLE;
                n_id = '0; n_total = '0; n_stored = '0; n_seq = '0; n_elapsed = '0;
            end
            isotp_pkg::OP_READ: begin
                o_cmd.rd_ok = isotp_pkg::RCVD_W'(i_item.read_index) < r_stored;
            end
            default: begin
            end
        endcase

        o_result.ev           = ev;
        o_result.phase        = isotp_pkg::phase_code(n_phase);
        o_result.fc_send      = fc;
        o_result.fc_id        = fcid;
        o_result.msg_total    = n_total;
        o_result.msg_received = n_stored;
        o_result.msg_id       = n_id;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= isotp_pkg::PH_IDLE;
            r_id      <= '0;
            r_total   <= '0;
            r_stored  <= '0;
            r_seq     <= '0;
            r_elapsed <= '0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_id      <= n_id;
            r_total   <= n_total;
            r_stored  <= n_stored;
            r_seq     <= n_seq;
            r_elapsed <= n_elapsed;
        end
    end

endmodule
